FILE: design/upv_pkg.sv
package upv_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SUM_W = WORD_W + 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED = 2'd2;

	localparam logic [WORD_W-1:0] FIRST_LIMIT_RST = 32'd2097152;
	localparam logic [WORD_W-1:0] SECOND_LIMIT_RST = 32'd1048576;
	localparam logic [WORD_W-1:0] CRC_SEED_RST = 32'hFFFF_FFFF;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FIRST_SIZE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SECOND_SIZE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH = 3'd6;

	// "BOOT", byte 0 in the low lane
	localparam logic [WORD_W-1:0] MAGIC = 32'h544F_4F42;
	localparam logic [WORD_W-1:0] HDR_BYTES = 32'd24;
	localparam logic [WORD_W-1:0] FOOT_BYTES = 32'd4;
	localparam logic [WORD_W-1:0] MIN_LEN = HDR_BYTES + FOOT_BYTES;
	localparam logic [WORD_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   first_image_size;
		logic [WORD_W-1:0]   second_image_size;
		logic [WORD_W-1:0]   extra_data_size;
	} out_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] first_image_limit;
		logic [WORD_W-1:0] second_image_limit;
		logic [WORD_W-1:0] crc_seed;
	} cfg_t;

	// reflected CRC-32, one byte, no final inversion
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
			input logic [7:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return c;
	endfunction

endpackage

FILE: design/upv_ifs.sv
interface upv_in_if ();
	logic               valid;
	logic               ready;
	upv_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface upv_out_if ();
	logic               valid;
	logic               ready;
	upv_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/upv_cfg.sv
module upv_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [upv_pkg::CFG_IDX_W-1:0] index,
	input  logic [upv_pkg::WORD_W-1:0]    wdata,
	output upv_pkg::cfg_t                 cfg
);
	import upv_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_image_limit <= FIRST_LIMIT_RST;
			cfg_q.second_image_limit <= SECOND_LIMIT_RST;
			cfg_q.crc_seed <= CRC_SEED_RST;
		end else if (wr_en) begin
			case (index)
				REG_FIRST_LIMIT: cfg_q.first_image_limit <= wdata;
				REG_SECOND_LIMIT: cfg_q.second_image_limit <= wdata;
				REG_CRC_SEED: cfg_q.crc_seed <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

FILE: design/upv_core.sv
module upv_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  upv_pkg::in_item_t  item,
	input  upv_pkg::cfg_t      cfg,
	output upv_pkg::out_item_t res
);
	import upv_pkg::*;

	logic [WORD_W-1:0] count_q;
	logic              magic_q;
	logic [WORD_W-1:0] first_q;
	logic [WORD_W-1:0] second_q;
	logic [WORD_W-1:0] extra_q;
	logic [WORD_W-1:0] tail_q;
	logic [WORD_W-1:0] crc_q;
	logic [SUM_W-1:0]  expect_q;

	logic [WORD_W-1:0] count_nx, first_nx, second_nx, extra_nx, tail_nx, crc_nx;
	logic              magic_nx;
	logic              in_magic, in_hdr;
	logic [1:0]        lane;
	logic              len_bad;

	assign in_magic = (count_q < 32'd4);
	assign in_hdr = !in_magic && (count_q < 32'd16);
	assign lane = count_q[1:0];

	always_comb begin
		magic_nx = magic_q;
		first_nx = first_q;
		second_nx = second_q;
		extra_nx = extra_q;
		if (in_magic) begin
			if (item.data_byte != MAGIC[8*lane +: 8])
				magic_nx = 1'b0;
		end else if (in_hdr) begin
			case (count_q[3:2])
				2'd1: first_nx[8*lane +: 8] = item.data_byte;
				2'd2: second_nx[8*lane +: 8] = item.data_byte;
				default: extra_nx[8*lane +: 8] = item.data_byte;
			endcase
		end
	end

	// bytes reach the CRC only once they drop out of the tail window, so the footer stays out of it
	assign crc_nx = in_magic ? crc_q : crc_byte(crc_q, tail_q[7:0]);
	assign tail_nx = {item.data_byte, tail_q[WORD_W-1:8]};
	assign count_nx = (count_q == COUNT_MAX) ? count_q : count_q + 32'd1;

	// sizes settle after byte 15, long before any length that passes the size check
	assign len_bad = (count_nx == COUNT_MAX) || (expect_q != {2'b00, count_nx});

	always_comb begin
		if (count_nx <= MIN_LEN)
			res.status = ST_TOO_SMALL;
		else if (!magic_q)
			res.status = ST_BAD_MAGIC;
		else if (first_q == '0 || first_q > cfg.first_image_limit)
			res.status = ST_FIRST_SIZE;
		else if (second_q == '0 || second_q > cfg.second_image_limit)
			res.status = ST_SECOND_SIZE;
		else if (len_bad)
			res.status = ST_LEN_MISMATCH;
		else if (crc_nx != tail_nx)
			res.status = ST_CRC_MISMATCH;
		else
			res.status = ST_OK;
		res.first_image_size = first_nx;
		res.second_image_size = second_nx;
		res.extra_data_size = extra_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			magic_q <= 1'b1;
			first_q <= '0;
			second_q <= '0;
			extra_q <= '0;
			tail_q <= '0;
			crc_q <= CRC_SEED_RST;
		end else if (step) begin
			if (item.final_byte) begin
				count_q <= '0;
				magic_q <= 1'b1;
				first_q <= '0;
				second_q <= '0;
				extra_q <= '0;
				tail_q <= '0;
				crc_q <= cfg.crc_seed;
			end else begin
				count_q <= count_nx;
				magic_q <= magic_nx;
				first_q <= first_nx;
				second_q <= second_nx;
				extra_q <= extra_nx;
				tail_q <= tail_nx;
				crc_q <= crc_nx;
			end
		end
	end

	// expected length, tracked from the size words every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			expect_q <= '0;
		else
			expect_q <= {2'b00, MIN_LEN} + {2'b00, first_q} + {2'b00, second_q}
				+ {2'b00, extra_q};
	end
endmodule

FILE: design/update_package_verifier_top.sv
// Flow: a package byte is registered in the input stage on transfer and is processed
//   when it leaves that stage; the status of a package is loaded into the result
//   register when its final byte leaves the input stage, and is offered from there.
// Throughput: one byte per cycle, limited only by the byte-wide CRC step;
//   the input stalls only while a final byte waits on an untaken status.
// Reset (arst_n low, asynchronous): limits and seed return to defaults,
//   package state clears, no item is held.
module update_package_verifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [upv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [upv_pkg::WORD_W-1:0]    cfg_wdata,
	upv_in_if.sink                        in_ch,
	upv_out_if.source                     out_ch
);
	import upv_pkg::*;

	cfg_t      cfg;

	// input stage
	logic      valid_s1;
	in_item_t  item_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	out_item_t res;
	logic      advance;
	logic      load_res;

	upv_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// A byte leaves the input stage unless it is a final byte and the
	// result register still holds a status nobody has taken.
	assign advance = valid_s1 && (!item_s1.final_byte || !out_valid_q || out_ch.ready);
	assign load_res = advance && item_s1.final_byte;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.valid && in_ch.ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_s1 <= in_ch.payload;
	end

	// Header capture, tail window, CRC and the status checks
	upv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_res)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_res)
			out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	// a pending status is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!out_valid_q || out_ch.ready))
		else $error("status overwritten before transfer");

	// a final byte blocked by the output holds the input stage
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.final_byte && out_valid_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while final byte blocked");

	// a status appears only after a final byte left the input stage
	a_status_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && item_s1.final_byte))
		else $error("status without final byte");

	// status code stays within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.status <= ST_CRC_MISMATCH))
		else $error("undefined status code");
endmodule

FILE: verif/upv_tb_pkg.sv
`timescale 1ns / 1ps

package upv_tb_pkg;

	// index past the last register; writes to it must change nothing
	localparam logic [upv_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// bit-serial reflected CRC-32, no final inversion
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = {1'b0, c[31:1]} ^ (fb ? upv_pkg::CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

FILE: verif/upv_status_checker.sv
`timescale 1ns / 1ps

module upv_status_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [upv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [upv_pkg::WORD_W-1:0]    cfg_wdata,
	upv_in_if                             in_mon,
	upv_out_if                            out_mon,
	output int                            mismatches,
	output int                            awaited
);
	import upv_pkg::*;

	cfg_t              regs;
	logic [31:0]       count;
	logic              magic_ok;
	logic [31:0]       first_sz;
	logic [31:0]       second_sz;
	logic [31:0]       extra_sz;
	logic [31:0]       tail;
	logic [31:0]       crc;
	out_item_t         status_due[$];
	int                fails = 0;
	int                pending = 0;

	assign mismatches = fails;
	assign awaited = pending;

	function void restart_package();
		count = '0;
		magic_ok = 1'b1;
		first_sz = '0;
		second_sz = '0;
		extra_sz = '0;
		tail = '0;
		crc = regs.crc_seed;
	endfunction

	function void absorb_byte(input logic [7:0] b, input logic fin);
		logic [31:0] pos;
		logic [33:0] want_len;
		out_item_t   r;
		pos = count;
		if (pos < 4) begin
			if (b != MAGIC[8*pos[1:0] +: 8])
				magic_ok = 1'b0;
		end else if (pos < 16) begin
			case (pos[3:2])
				2'd1: first_sz[8*pos[1:0] +: 8] = b;
				2'd2: second_sz[8*pos[1:0] +: 8] = b;
				default: extra_sz[8*pos[1:0] +: 8] = b;
			endcase
		end
		// bytes reach the CRC only once they drop out of the footer window
		if (pos >= FOOT_BYTES)
			crc = upv_tb_pkg::crc_feed(crc, tail[7:0]);
		tail = {b, tail[31:8]};
		if (count != COUNT_MAX)
			count++;
		if (!fin)
			return;
		want_len = {2'b00, HDR_BYTES} + {2'b00, first_sz} + {2'b00, second_sz}
			+ {2'b00, extra_sz} + {2'b00, FOOT_BYTES};
		if (count <= MIN_LEN)
			r.status = ST_TOO_SMALL;
		else if (!magic_ok)
			r.status = ST_BAD_MAGIC;
		else if (first_sz == 0 || first_sz > regs.first_image_limit)
			r.status = ST_FIRST_SIZE;
		else if (second_sz == 0 || second_sz > regs.second_image_limit)
			r.status = ST_SECOND_SIZE;
		else if (count == COUNT_MAX || want_len != {2'b00, count})
			r.status = ST_LEN_MISMATCH;
		else if (crc != tail)
			r.status = ST_CRC_MISMATCH;
		else
			r.status = ST_OK;
		r.first_image_size = first_sz;
		r.second_image_size = second_sz;
		r.extra_data_size = extra_sz;
		status_due.push_back(r);
		restart_package();
	endfunction

	function void field_check(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected 'h%08h, actual 'h%08h", $time, what, want, got);
		end
	endfunction

	function void check_status(input out_item_t got);
		out_item_t want;
		if (status_due.size() == 0) begin
			fails++;
			$display("%0t: unexpected status transfer, expected none, actual status %0d",
				$time, got.status);
			return;
		end
		want = status_due.pop_front();
		field_check("status", 32'(want.status), 32'(got.status));
		field_check("first_image_size", want.first_image_size, got.first_image_size);
		field_check("second_image_size", want.second_image_size, got.second_image_size);
		field_check("extra_data_size", want.extra_data_size, got.extra_data_size);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.first_image_limit = FIRST_LIMIT_RST;
			regs.second_image_limit = SECOND_LIMIT_RST;
			regs.crc_seed = CRC_SEED_RST;
			restart_package();
			status_due.delete();
			pending = 0;
		end else begin
			if (out_mon.valid && out_mon.ready)
				check_status(out_mon.payload);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_FIRST_LIMIT: regs.first_image_limit = cfg_wdata;
					REG_SECOND_LIMIT: regs.second_image_limit = cfg_wdata;
					REG_CRC_SEED: regs.crc_seed = cfg_wdata;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				absorb_byte(in_mon.payload.data_byte, in_mon.payload.final_byte);
			pending = status_due.size();
		end
	end

endmodule

FILE: verif/update_package_verifier_top_tb.sv
`timescale 1ns / 1ps

module update_package_verifier_top_tb;
	import upv_pkg::*;

	// how a side spaces its transfers during one phase
	typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

	// ways to spoil a generated package
	localparam int FLAW_MAGIC = 1;
	localparam int FLAW_CRC = 2;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_wdata;
	int                   mismatches;
	int                   awaited;

	upv_in_if  in_ch ();
	upv_out_if out_ch ();

	update_package_verifier_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	upv_status_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	// stimulus-side view of the registers; pkg_seed is the seed latched at the
	// end of the previous package, which is what the next package's CRC starts from
	logic [31:0] cur_lim1;
	logic [31:0] cur_lim2;
	logic [31:0] cur_seed;
	logic [31:0] pkg_seed;
	logic [7:0]  pkt[$];
	idle_mode_t  tx_mode;
	idle_mode_t  rx_mode;
	bit          hold_req;
	int          sent_bytes;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit, far above the slowest legal run
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_FULL: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// result side: one drawn wait per status; a requested hold keeps ready low
	// for a long stretch so the block backs up into its input
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 300;
			end else
				stall = pick_gap(rx_mode);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{data_byte: b, final_byte: fin};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_pkt();
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1, pick_gap(tx_mode));
		sent_bytes += pkt.size();
		pkg_seed = cur_seed;
	endtask

	// header, body of body_len random bytes, footer over everything before it;
	// keep_len > 0 cuts the package down to that many bytes
	task automatic build_pkt(input logic [31:0] s1, input logic [31:0] s2,
			input logic [31:0] s3, input int body_len, input int flaws, input int keep_len);
		logic [31:0] c;
		pkt.delete();
		for (int i = 0; i < 4; i++)
			pkt.push_back(MAGIC[8*i +: 8]);
		if (flaws & FLAW_MAGIC)
			pkt[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < 4; i++)
			pkt.push_back(s1[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			pkt.push_back(s2[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			pkt.push_back(s3[8*i +: 8]);
		repeat (8 + body_len) pkt.push_back(8'($urandom));
		c = pkg_seed;
		foreach (pkt[i])
			c = upv_tb_pkg::crc_feed(c, pkt[i]);
		if (flaws & FLAW_CRC)
			c ^= 32'd1 << $urandom_range(0, 31);
		for (int i = 0; i < 4; i++)
			pkt.push_back(c[8*i +: 8]);
		if (keep_len > 0)
			while (pkt.size() > keep_len)
				void'(pkt.pop_back());
	endtask

	task automatic noise_pkt(input int n);
		pkt.delete();
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	// drop valid, let every status drain, then let the pipeline idle before returning
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [31:0] l1, input logic [31:0] l2,
			input logic [31:0] seed, input bit stray);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FIRST_LIMIT;
		cfg_wdata <= l1;
		@(negedge clk);
		cfg_index <= REG_SECOND_LIMIT;
		cfg_wdata <= l2;
		@(negedge clk);
		cfg_index <= REG_CRC_SEED;
		cfg_wdata <= seed;
		@(negedge clk);
		if (stray) begin
			cfg_index <= upv_tb_pkg::REG_SPARE;
			cfg_wdata <= $urandom;
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_lim1 = l1;
		cur_lim2 = l2;
		cur_seed = seed;
	endtask

	// one package of a randomly chosen shape; bodies stay short even where a size word is large
	task automatic random_pkt();
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] s3;
		int          sum;
		int          d;
		int          r;
		s1 = $urandom_range(1, (cur_lim1 < 12) ? cur_lim1 : 12);
		s2 = $urandom_range(1, (cur_lim2 < 12) ? cur_lim2 : 12);
		s3 = $urandom_range(0, 12);
		sum = s1 + s2 + s3;
		r = $urandom_range(0, 99);
		if (r < 55)
			build_pkt(s1, s2, s3, sum, 0, 0);
		else if (r < 63)
			build_pkt(s1, s2, s3, sum, FLAW_CRC, 0);
		else if (r < 70) begin
			if ($urandom_range(0, 3) == 0)
				build_pkt(s1, s2, $urandom, sum, 0, 0);
			else begin
				d = $urandom_range(1, 3);
				build_pkt(s1, s2, s3, ($urandom_range(0, 1) && sum >= d) ? sum - d : sum + d,
					0, 0);
			end
		end else if (r < 76)
			build_pkt(s1, s2, s3, sum, FLAW_MAGIC, 0);
		else if (r < 82) begin
			case ($urandom_range(0, 3))
				0: s1 = 0;
				1: s1 = (cur_lim1 == '1) ? 32'd0 : cur_lim1 + 1;
				2: s2 = 0;
				default: s2 = (cur_lim2 == '1) ? 32'd0 : cur_lim2 + 1;
			endcase
			build_pkt(s1, s2, s3, $urandom_range(2, 20), 0, 0);
		end else if (r < 90)
			build_pkt(s1, s2, s3, sum, 0, $urandom_range(1, 28));
		else
			noise_pkt($urandom_range(1, 48));
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FIRST_LIMIT;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		hold_req = 1'b0;
		tx_mode = IDLE_SPARSE;
		rx_mode = IDLE_SPARSE;
		cur_lim1 = FIRST_LIMIT_RST;
		cur_lim2 = SECOND_LIMIT_RST;
		cur_seed = CRC_SEED_RST;
		pkg_seed = CRC_SEED_RST;
		sent_bytes = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed packages on the reset settings
		noise_pkt(1);
		pkt[0] = 8'h00;
		send_pkt();                                   // one byte, all zero
		pkt[0] = 8'hFF;
		send_pkt();                                   // one byte, all ones
		build_pkt(1, 1, 0, 2, 0, 28);
		send_pkt();                                   // exactly the minimum length: too small
		build_pkt(1, 1, 0, 1, 0, 0);
		send_pkt();                                   // one past the minimum, short body
		build_pkt(1, 1, 0, 2, 0, 0);
		send_pkt();                                   // smallest good package
		build_pkt(2, 1, 3, 6, FLAW_MAGIC, 0);
		send_pkt();
		build_pkt(0, 1, 0, 1, 0, 0);
		send_pkt();                                   // first size zero
		build_pkt(FIRST_LIMIT_RST + 1, 1, 0, 4, 0, 0);
		send_pkt();                                   // first size one over its limit
		build_pkt(FIRST_LIMIT_RST, SECOND_LIMIT_RST, 0, 4, 0, 0);
		send_pkt();                                   // both sizes at their limits
		build_pkt(1, 0, 0, 1, 0, 0);
		send_pkt();                                   // second size zero
		build_pkt(1, SECOND_LIMIT_RST + 1, 0, 4, 0, 0);
		send_pkt();
		build_pkt(3, 2, 1, 6, FLAW_CRC, 0);
		send_pkt();
		build_pkt(2, 2, 2, 7, 0, 0);
		send_pkt();                                   // one byte too long
		build_pkt(32'h1122_3344, 32'h5566_7788, 32'h99AA_BBCC, 0, 0, 10);
		send_pkt();                                   // cut inside the second size word
		settle();

		// widest limits: size words of all ones overflow 32 bits when summed
		write_cfg('1, '1, 32'h0, 1'b0);
		build_pkt('1, '1, '1, 2, 0, 0);
		send_pkt();                                   // still on the previous seed
		build_pkt(5, 4, 3, 12, 0, 0);
		send_pkt();                                   // first package on a zero seed
		build_pkt(1, 1, 0, 2, 0, 0);
		send_pkt();                                   // again on the zero seed

		// random phases, each on its own register setting and idling mix
		phase = 0;
		while (sent_bytes < 850 || phase < 3) begin
			settle();
			case (phase % 5)
				0: write_cfg(32'd1, 32'd1, 32'h0, 1'b0);
				1: write_cfg('1, '1, '1, 1'b0);
				2: write_cfg($urandom_range(1, 12), $urandom_range(1, 12), $urandom, 1'b1);
				3: write_cfg($urandom | 32'd1, $urandom | 32'd1, $urandom, 1'b0);
				default: write_cfg(FIRST_LIMIT_RST, SECOND_LIMIT_RST, CRC_SEED_RST, 1'b1);
			endcase
			tx_mode = idle_mode_t'($urandom_range(0, 2));
			rx_mode = idle_mode_t'($urandom_range(0, 2));
			if (phase == 2) begin
				// back-to-back short packages against a long output stall
				hold_req = 1'b1;
				tx_mode = IDLE_NONE;
				repeat (8) begin
					if ($urandom_range(0, 1))
						noise_pkt($urandom_range(1, 6));
					else
						build_pkt(1, 1, 0, 2, 0, $urandom_range(1, 6));
					send_pkt();
				end
			end else begin
				repeat (4) begin
					random_pkt();
					send_pkt();
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
